### sv/pva_pkg.sv
// ----------------------------------------------------------------------------
// Pointer velocity averager package
// Shared constants, beat types and the control structs between the
// sequencer and the per-axis lanes.
// ----------------------------------------------------------------------------
package pva_pkg;

  // Ring depth and the widths that follow from it.
  localparam int DEPTH     = 16;
  localparam int SLOT_W    = $clog2(DEPTH);
  localparam int FILL_W    = 5;
  localparam int SUM_W     = 36;
  localparam int DIV_STEPS = SUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Input beat.
  typedef struct packed {
    logic               restart;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic        [31:0] timestamp;
  } sample_t;

  // Result beat.
  typedef struct packed {
    logic signed [31:0] avg_vx;
    logic signed [31:0] avg_vy;
    logic [FILL_W-1:0]  samples_held;
    logic               accepted;
  } result_t;

  // Commands from the sequencer to both lanes.
  typedef struct packed {
    logic              start_vel;
    logic              start_mean;
    logic              clear;
    logic              full;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       dt;
    logic [FILL_W-1:0] count;
  } lane_cmd_t;

  // Status returned by each lane.
  typedef struct packed {
    logic               vel_done;
    logic               mean_done;
    logic signed [31:0] mean;
  } lane_stat_t;

endpackage

### sv/pva_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Unsigned restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pva_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pva_pkg::SUM_W-1:0]    dividend,
  input  logic [31:0]                  divisor,
  output logic                         done,
  output logic [pva_pkg::SUM_W-1:0]    quotient
);

  logic                        busy;
  logic [pva_pkg::CNT_W-1:0]   cnt;
  logic [31:0]                 rem;
  logic [31:0]                 dvs;
  logic [pva_pkg::SUM_W-1:0]   quo;
  logic [32:0]                 trial;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign trial = {rem, quo[pva_pkg::SUM_W-1]} - {1'b0, dvs};

  // Control: step counter and the completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == pva_pkg::CNT_W'(pva_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[pva_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[pva_pkg::SUM_W-1]};
        quo <= {quo[pva_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

### sv/pva_lane.sv
// ----------------------------------------------------------------------------
// Axis lane
// Velocity division, history ring, running sum and mean division for one
// axis.
// ----------------------------------------------------------------------------
module pva_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  pva_pkg::lane_cmd_t    cmd,
  input  logic signed [15:0]    d,
  output pva_pkg::lane_stat_t   stat
);

  localparam logic MODE_VEL  = 1'b0;
  localparam logic MODE_MEAN = 1'b1;

  logic signed [31:0]              hist [pva_pkg::DEPTH];
  logic signed [pva_pkg::SUM_W-1:0] sum;
  logic                            mode;
  logic                            neg;
  logic                            div_start;
  logic [pva_pkg::SUM_W-1:0]       div_dividend;
  logic [31:0]                     div_divisor;
  logic                            div_done;
  logic [pva_pkg::SUM_W-1:0]       div_q;
  logic [15:0]                     d_mag;
  logic [pva_pkg::SUM_W-1:0]       sum_mag;
  logic signed [31:0]              signed_q;
  logic signed [pva_pkg::SUM_W-1:0] sum_next;
  logic signed [pva_pkg::SUM_W-1:0] old_val;

  // Operand magnitudes for the unsigned divider.
  assign d_mag   = d[15] ? 16'(-d) : 16'(d);
  assign sum_mag = sum[pva_pkg::SUM_W-1] ? pva_pkg::SUM_W'(-sum) : pva_pkg::SUM_W'(sum);

  // Divider operand selection.
  always_comb begin
    div_start    = cmd.start_vel | cmd.start_mean;
    div_dividend = {4'b0, d_mag, 16'b0};
    div_divisor  = cmd.dt;
    if (cmd.start_mean) begin
      div_dividend = sum_mag;
      div_divisor  = {{(32 - pva_pkg::FILL_W){1'b0}}, cmd.count};
    end
  end

  pva_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Restore the sign; the quotient always fits in 32 bits.
  assign signed_q = neg ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);

  // Entry about to be overwritten, read while the velocity divide starts.
  // The slot and the full flag hold still until the divide is done.
  always_ff @(posedge clk) begin
    if (cmd.start_vel) begin
      old_val <= cmd.full ? pva_pkg::SUM_W'(hist[cmd.slot]) : '0;
    end
  end

  // Running sum: add the new velocity and drop the one it overwrites.
  assign sum_next = sum + pva_pkg::SUM_W'(signed_q) - old_val;

  // Remember the operation in flight and its sign.
  always_ff @(posedge clk) begin
    if (cmd.start_vel) begin
      mode <= MODE_VEL;
      neg  <= d[15];
    end else if (cmd.start_mean) begin
      mode <= MODE_MEAN;
      neg  <= sum[pva_pkg::SUM_W-1];
    end
  end

  // Running sum is control state: reset and restart empty it.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sum <= '0;
    end else if (div_done && mode == MODE_VEL) begin
      sum <= sum_next;
    end
  end

  // History ring write.
  always_ff @(posedge clk) begin
    if (div_done && mode == MODE_VEL) begin
      hist[cmd.slot] <= signed_q;
    end
  end

  assign stat.vel_done  = div_done && (mode == MODE_VEL);
  assign stat.mean_done = div_done && (mode == MODE_MEAN);
  assign stat.mean      = signed_q;

endmodule

### sv/pointer_velocity_averager.sv
// ----------------------------------------------------------------------------
// Pointer velocity averager
// Turns pointer displacement beats into a moving average of velocity.
// ----------------------------------------------------------------------------
// Usage: the sample channel (sample_valid, sample_stall, sample) carries one
// beat per pointer event; the result channel (result_valid, result_stall,
// result) returns exactly one beat for each sample beat, in order.
// A restart beat, or a beat whose timestamp is not later than the reference,
// goes straight to the hold state and from there into the output register. A
// stored sample goes through two divisions in each axis lane, a velocity
// divide and a mean divide, each on the bit-serial divider, before its result
// is held; that divider keeps the block to one beat in flight.
// The next sample is taken as soon as the previous one is finished, even if
// its result still sits in the output register.
// Reset clears the reference time, the fill count and the running sums; the
// block is ready for a sample as soon as reset is released.
// When the receiver stalls, the result beat holds steady; a finished beat
// behind it waits, and sample_stall stays high until it can move.
// ----------------------------------------------------------------------------
module pointer_velocity_averager (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  pva_pkg::sample_t     sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output pva_pkg::result_t     result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_VEL  = 2'd1;
  localparam logic [1:0] ST_MEAN = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]                  state;
  logic [31:0]                 ref_time;
  logic [pva_pkg::FILL_W-1:0]  fill;
  logic [pva_pkg::SLOT_W-1:0]  ovr_slot;
  logic signed [31:0]          cur_vx;
  logic signed [31:0]          cur_vy;
  logic                        acc;
  logic                        mean_go;
  logic                        take;
  logic                        later;
  logic                        full;
  logic                        load_out;
  pva_pkg::lane_cmd_t          cmd;
  pva_pkg::lane_stat_t         stat_x;
  pva_pkg::lane_stat_t         stat_y;

  assign sample_stall = (state != ST_IDLE);
  assign take         = sample_valid && !sample_stall;
  assign later        = sample.timestamp > ref_time;
  assign full         = (fill == pva_pkg::FILL_W'(pva_pkg::DEPTH));
  assign load_out     = (state == ST_HOLD) && (!result_valid || !result_stall);

  // Lane commands.
  always_comb begin
    cmd.start_vel  = take && !sample.restart && later;
    cmd.start_mean = mean_go;
    cmd.clear      = take && sample.restart;
    cmd.full       = full;
    cmd.slot       = full ? ovr_slot : fill[pva_pkg::SLOT_W-1:0];
    cmd.dt         = sample.timestamp - ref_time;
    cmd.count      = fill;
  end

  pva_lane u_lane_x (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .d    (sample.dx),
    .stat (stat_x)
  );

  pva_lane u_lane_y (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .d    (sample.dy),
    .stat (stat_y)
  );

  // Sequencer, ring bookkeeping and merging of the lane means.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ref_time <= '0;
      fill     <= '0;
      ovr_slot <= '0;
      cur_vx   <= '0;
      cur_vy   <= '0;
      acc      <= 1'b0;
      mean_go  <= 1'b0;
    end else begin
      mean_go <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (take) begin
            if (sample.restart) begin
              ref_time <= sample.timestamp;
              fill     <= '0;
              ovr_slot <= '0;
              cur_vx   <= '0;
              cur_vy   <= '0;
              acc      <= 1'b0;
              state    <= ST_HOLD;
            end else if (later) begin
              ref_time <= sample.timestamp;
              acc      <= 1'b1;
              state    <= ST_VEL;
            end else begin
              acc   <= 1'b0;
              state <= ST_HOLD;
            end
          end
        end
        ST_VEL: begin
          if (stat_x.vel_done && stat_y.vel_done) begin
            if (!full) begin
              fill <= fill + 1'b1;
            end else if (ovr_slot == pva_pkg::SLOT_W'(pva_pkg::DEPTH - 1)) begin
              ovr_slot <= '0;
            end else begin
              ovr_slot <= ovr_slot + 1'b1;
            end
            mean_go <= 1'b1;
            state   <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          if (stat_x.mean_done && stat_y.mean_done) begin
            cur_vx <= stat_x.mean;
            cur_vy <= stat_y.mean;
            state  <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load_out) begin
      result.avg_vx       <= cur_vx;
      result.avg_vy       <= cur_vy;
      result.samples_held <= fill;
      result.accepted     <= acc;
    end
  end

endmodule

### sv/pva_checker.sv
// ----------------------------------------------------------------------------
// Pointer velocity averager checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module pva_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_stall,
  input pva_pkg::sample_t  sample,
  input logic              result_valid,
  input logic              result_stall,
  input pva_pkg::result_t  result
);

  // No result beat straight after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat valid right after reset");

  // A stalled result beat stays put.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  // A stalled sample beat stays put.
  a_sample_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_stall |=> sample_valid && $stable(sample))
    else $error("stalled sample beat changed");

  // A stored sample leaves at least one entry in the ring.
  a_stored_nonempty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.accepted |-> result.samples_held != 5'd0)
    else $error("sample stored but ring reported empty");

  // An empty ring averages to zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.samples_held == 5'd0 |->
      result.avg_vx == 32'sd0 && result.avg_vy == 32'sd0)
    else $error("non-zero mean with empty ring");

endmodule

bind pointer_velocity_averager pva_checker u_pva_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .sample       (sample),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

### tb/pointer_velocity_averager_tb.sv
// ----------------------------------------------------------------------------
// Pointer velocity averager testbench
// Runs a short directed table first: the empty history, restarts, stale
// timestamps, the displacement and timestamp extremes and a wrap of the full
// ring. A long random run of restart-delimited strokes follows. Every result
// beat is checked field by field against the table row's result where it
// gives one, else against a local velocity and mean predictor. Both channels
// idle at random; two long receiver hold-offs back the block into its input.
// ----------------------------------------------------------------------------
module pointer_velocity_averager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One row of the directed table: a beat and, where it is obvious, its result.
  typedef struct packed {
    pva_pkg::sample_t beat;
    logic             typed;
    pva_pkg::result_t want;
  } dir_row_t;

  localparam pva_pkg::result_t NO_MEAN      = '0;
  localparam int               NDIR         = 26;
  localparam int               RANDOM_BEATS = 1300;
  localparam int               HOLD_OFF     = 400;
  localparam int               TAIL         = 120;

  localparam dir_row_t DIR_ROWS [NDIR] = '{
    // Empty history, timestamp equal to the reset reference.
    '{'{1'b0, 16'h7FFF, 16'h8000, 32'd0}, 1'b1, NO_MEAN},
    // Restart ignores its displacements.
    '{'{1'b1, 16'h8000, 16'h7FFF, 32'd1000}, 1'b1, NO_MEAN},
    // Largest displacements over one tick.
    '{'{1'b0, 16'h7FFF, 16'h8000, 32'd1001}, 1'b1,
      '{32'h7FFF0000, 32'h80000000, 5'd1, 1'b1}},
    // Equal and earlier timestamps leave the history alone.
    '{'{1'b0, 16'sd5, 16'sd5, 32'd1001}, 1'b0, NO_MEAN},
    '{'{1'b0, 16'sd5, 16'sd5, 32'd500}, 1'b0, NO_MEAN},
    // Fill the ring.
    '{'{1'b0, -16'sd1, 16'sd1, 32'd1003}, 1'b0, NO_MEAN},
    '{'{1'b0, 16'sd100, -16'sd100, 32'd1006}, 1'b0, NO_MEAN},
    '{'{1'b0, 16'h8000, 16'sd0, 32'd1013}, 1'b0, NO_MEAN},
    '{'{1'b0, 16'sd3, -16'sd7, 32'd1014}, 1'b0, NO_MEAN},
    '{'{1'b0, -16'sd12345, 16'sd23456, 32'd1114}, 1'b0, NO_MEAN},
    '{'{1'b0, 16'sd0, 16'sd0, 32'd1115}, 1'b0, NO_MEAN},
    '{'{1'b0, 16'sd17, -16'sd17, 32'd1131}, 1'b0, NO_MEAN},
    '{'{1'b0, 16'h7FFF, 16'h7FFF, 32'd1132}, 1'b0, NO_MEAN},
    '{'{1'b0, -16'sd1, -16'sd1, 32'd71132}, 1'b0, NO_MEAN},
    '{'{1'b0, 16'sd1000, -16'sd2000, 32'd71133}, 1'b0, NO_MEAN},
    '{'{1'b0, -16'sd333, 16'sd333, 32'd71135}, 1'b0, NO_MEAN},
    '{'{1'b0, 16'sd7, 16'sd9, 32'd71140}, 1'b0, NO_MEAN},
    '{'{1'b0, 16'h8000, 16'h8000, 32'd71141}, 1'b0, NO_MEAN},
    '{'{1'b0, 16'sd42, -16'sd42, 32'd71142}, 1'b0, NO_MEAN},
    '{'{1'b0, -16'sd5000, 16'sd5000, 32'd71150}, 1'b0, NO_MEAN},
    // Two more overwrite the oldest entries.
    '{'{1'b0, 16'sd11, -16'sd13, 32'd71151}, 1'b0, NO_MEAN},
    '{'{1'b0, -16'sd29, 16'sd31, 32'd71153}, 1'b0, NO_MEAN},
    // Top of the timestamp range.
    '{'{1'b1, 16'sd0, 16'sd0, 32'hFFFFFFFE}, 1'b1, NO_MEAN},
    '{'{1'b0, 16'h8000, 16'h7FFF, 32'hFFFFFFFF}, 1'b1,
      '{32'h80000000, 32'h7FFF0000, 5'd1, 1'b1}},
    // Longest possible interval.
    '{'{1'b1, 16'sd9, 16'sd9, 32'd0}, 1'b1, NO_MEAN},
    '{'{1'b0, 16'sd100, -16'sd100, 32'hFFFFFFFF}, 1'b0, NO_MEAN}
  };

  logic             clk = 1'b0;
  logic             rst;
  logic             sample_valid;
  logic             sample_stall;
  pva_pkg::sample_t sample;
  logic             result_valid;
  logic             result_stall;
  pva_pkg::result_t result;

  // Predictor state.
  logic        [31:0] ref_time_m = '0;
  logic signed [31:0] vel_x_m [pva_pkg::DEPTH];
  logic signed [31:0] vel_y_m [pva_pkg::DEPTH];
  int unsigned        fill_m   = 0;
  int unsigned        oldest_m = 0;

  pva_pkg::result_t expected_means [$];
  int      errors       = 0;
  int      n_checked    = 0;
  int      n_stored     = 0;
  int      n_overwrites = 0;
  int      n_restarts   = 0;
  int      n_stale      = 0;

  pointer_velocity_averager DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one beat to the predictor state and returns the mean it reports.
  function automatic pva_pkg::result_t velocity_mean_after(pva_pkg::sample_t s);
    longint           dt;
    longint           acc_x;
    longint           acc_y;
    int unsigned      slot;
    pva_pkg::result_t r;
    r = '0;
    if (s.restart) begin
      ref_time_m = s.timestamp;
      fill_m     = 0;
      oldest_m   = 0;
      n_restarts++;
    end else if (s.timestamp > ref_time_m) begin
      dt = s.timestamp;
      dt = dt - ref_time_m;
      if (fill_m < pva_pkg::DEPTH) begin
        slot = fill_m;
        fill_m++;
      end else begin
        slot     = oldest_m;
        oldest_m = (oldest_m + 1) % pva_pkg::DEPTH;
        n_overwrites++;
      end
      acc_x = s.dx;
      acc_y = s.dy;
      vel_x_m[slot] = 32'((acc_x * 65536) / dt);
      vel_y_m[slot] = 32'((acc_y * 65536) / dt);
      ref_time_m = s.timestamp;
      r.accepted = 1'b1;
      n_stored++;
    end else begin
      n_stale++;
    end
    // Truncated mean over the held entries only.
    acc_x = 0;
    acc_y = 0;
    for (int i = 0; i < fill_m; i++) begin
      acc_x += vel_x_m[i];
      acc_y += vel_y_m[i];
    end
    if (fill_m != 0) begin
      r.avg_vx = 32'(acc_x / longint'(fill_m));
      r.avg_vy = 32'(acc_y / longint'(fill_m));
    end
    r.samples_held = pva_pkg::FILL_W'(fill_m);
    return r;
  endfunction

  // Displacement with a bias towards the extremes and the values around zero.
  function automatic logic signed [15:0] displacement();
    case ($urandom_range(0, 19))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one beat after an idle gap and records its expected result on
  // acceptance.
  task automatic send_beat(input pva_pkg::sample_t s, input int gap, input logic typed,
                           input pva_pkg::result_t want);
    pva_pkg::result_t predicted;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall !== 1'b0);
    predicted = velocity_mean_after(s);
    expected_means.push_back(typed ? want : predicted);
  endtask

  // Sender: reset, the directed table, then random strokes.
  initial begin : stimulus
    pva_pkg::sample_t s;
    int unsigned      kind;
    int unsigned      span;
    logic [31:0]      headroom;
    logic [31:0]      dt;
    int               gap;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[i]) begin
      send_beat(DIR_ROWS[i].beat, $urandom_range(0, 8), DIR_ROWS[i].typed,
                DIR_ROWS[i].want);
    end

    // Mostly strokes of rising timestamps, with restarts and stale beats.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      s.restart = 1'b0;
      s.dx      = displacement();
      s.dy      = displacement();
      kind      = $urandom_range(0, 99);
      headroom  = 32'hFFFFFFFF - ref_time_m;
      if (kind < 4 || (kind >= 10 && headroom == 0)) begin
        s.restart   = 1'b1;
        s.timestamp = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4095);
      end else if (kind < 10) begin
        s.timestamp = ref_time_m -
                      $urandom_range(0, (ref_time_m < 64) ? ref_time_m : 64);
      end else begin
        span = $urandom_range(0, 9);
        if (span < 6) begin
          dt = $urandom_range(1, 16);
        end else if (span < 9) begin
          dt = $urandom_range(17, 65535);
        end else begin
          dt = $urandom_range(1, 32'hFFFFFFFF);
        end
        if (dt > headroom) begin
          dt = headroom;
        end
        s.timestamp = ref_time_m + dt;
      end
      gap = ((n % 200) >= 150) ? 0 : $urandom_range(0, 8);
      send_beat(s, gap, 1'b0, NO_MEAN);
    end
    sample_valid <= 1'b0;

    // Drain, then give any stray beat time to show up.
    while (expected_means.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("Sent %0d beats: %0d samples stored (%0d overwriting the oldest), %0d restarts,",
             NDIR + RANDOM_BEATS, n_stored, n_overwrites, n_restarts);
    $display("%0d stale timestamps; %0d result beats checked, %0d mismatches.",
             n_stale, n_checked, errors);
    if (errors == 0) begin
      $display("pointer_velocity_averager_tb: clean");
    end else begin
      $display("pointer_velocity_averager_tb: errors");
    end
    $finish;
  end

  // Receiver: checks each result beat and then stalls for a random stretch, or for a long hold-off twice.
  initial begin : receiver
    int               hold;
    pva_pkg::result_t want;
    hold = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_valid === 1'b1 && result_stall === 1'b0) begin
        if (expected_means.size() == 0) begin
          $display("%0t: result beat %h arrived with nothing expected", $time, result);
          errors++;
        end else begin
          want = expected_means.pop_front();
          if (result.avg_vx !== want.avg_vx) begin
            $display("%0t: avg_vx expected %0d, got %0d", $time, want.avg_vx, result.avg_vx);
            errors++;
          end
          if (result.avg_vy !== want.avg_vy) begin
            $display("%0t: avg_vy expected %0d, got %0d", $time, want.avg_vy, result.avg_vy);
            errors++;
          end
          if (result.samples_held !== want.samples_held) begin
            $display("%0t: samples_held expected %0d, got %0d", $time,
                     want.samples_held, result.samples_held);
            errors++;
          end
          if (result.accepted !== want.accepted) begin
            $display("%0t: accepted expected %0b, got %0b", $time,
                     want.accepted, result.accepted);
            errors++;
          end
        end
        n_checked++;
        // Two long hold-offs let the block back up into its input.
        if (n_checked == 300 || n_checked == 900) begin
          hold = HOLD_OFF;
        end else begin
          hold = ((n_checked % 180) >= 130) ? 0 : $urandom_range(0, 8);
        end
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        hold--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Watchdog, several times the slowest correct run.
  initial begin : watchdog
    #10ms;
    $display("%0t: timed out with %0d results outstanding", $time, expected_means.size());
    $display("pointer_velocity_averager_tb: errors");
    $finish;
  end

endmodule
